>>> design/grid_bilinear_table_lookup_defines.svh
// ----------------------------------------------------------------------------
// grid_bilinear_table_lookup_defines.svh
// Assertion macros shared by the lookup block.
// ----------------------------------------------------------------------------
`ifndef GRID_BILINEAR_TABLE_LOOKUP_DEFINES_SVH
`define GRID_BILINEAR_TABLE_LOOKUP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define GBL_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define GBL_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define GBL_ASSERT(lbl, clk, rstn, prop)
`define GBL_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

>>> design/gbl_pkg.sv
// ----------------------------------------------------------------------------
// gbl_pkg
// Types and constants of the grid bilinear lookup.
// ----------------------------------------------------------------------------
package gbl_pkg;

  localparam int unsigned VAL_W   = 17;
  localparam int unsigned PT_W    = 32;
  localparam int unsigned NUM_W   = 50;
  localparam logic [VAL_W-1:0] FULL_SCALE = 17'd65536;
  localparam logic [PT_W:0]    ON_POINT_TOL = 33'sd1;

  typedef enum logic [1:0] {
    KIND_ALT  = 2'd0,
    KIND_COS  = 2'd1,
    KIND_CELL = 2'd2,
    KIND_QRY  = 2'd3
  } kind_t;

  typedef enum logic [0:0] {
    CFG_SHELLS = 1'b0,
    CFG_ANGLES = 1'b1
  } cfg_idx_t;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_ASCAN = 11'b000_0000_0010,
    ST_CSCAN = 11'b000_0000_0100,
    ST_RDLO  = 11'b000_0000_1000,
    ST_RDHI  = 11'b000_0001_0000,
    ST_RDWT  = 11'b000_0010_0000,
    ST_MULA  = 11'b000_0100_0000,
    ST_MULB  = 11'b000_1000_0000,
    ST_SUM   = 11'b001_0000_0000,
    ST_DIV   = 11'b010_0000_0000,
    ST_FIN   = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [PT_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [VAL_W-1:0] quot;
  } div_rsp_t;

endpackage

>>> design/gbl_ram.sv
// ----------------------------------------------------------------------------
// gbl_ram
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------------------
module gbl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/gbl_div.sv
// ----------------------------------------------------------------------------
// gbl_div
// Restoring divider, one quotient bit per cycle, 17-bit quotient.
// ----------------------------------------------------------------------------
module gbl_div (
  input  logic              clk,
  input  logic              rst_n,
  input  gbl_pkg::div_req_t req,
  output gbl_pkg::div_rsp_t rsp
);

  localparam int unsigned QW = gbl_pkg::VAL_W;
  localparam int unsigned DW = gbl_pkg::PT_W;

  logic [DW-1:0]         rem_r, rem_nxt;
  logic [QW-1:0]         sh_r, sh_nxt;
  logic [QW-1:0]         q_r, q_nxt;
  logic [DW-1:0]         den_r, den_nxt;
  logic [$clog2(QW):0]   cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic [DW:0]           trial;
  logic [DW:0]           diff;

  always_comb begin
    trial    = {rem_r, sh_r[QW-1]};
    diff     = trial - {1'b0, den_r};
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt = req.num[QW+DW-1:QW];
      sh_nxt  = req.num[QW-1:0];
      den_nxt = req.den;
      cnt_nxt = ($clog2(QW)+1)'(QW);
    end else if (cnt_r != '0) begin
      sh_nxt  = {sh_r[QW-2:0], 1'b0};
      if (!diff[DW]) begin
        rem_nxt = diff[DW-1:0];
        q_nxt   = {q_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        q_nxt   = {q_r[QW-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == ($clog2(QW)+1)'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy = (cnt_r != '0);
  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

>>> design/grid_bilinear_table_lookup.sv
// ----------------------------------------------------------------------------
// grid_bilinear_table_lookup
// Bilinear transmission lookup over a non-uniform altitude/cosine grid.
//
//  channel  dir  handshake           payload
//  in_      in   tvalid/tready       tuser kind, tdata write/query fields
//  out_     out  tvalid/tready       tuser below flag, tdata transmission
//  cfg_     in   we                  index, wdata
//
//  Write items are written as they are accepted. A query scans the altitude
//  grid, then the cosine grid, reads the table columns, runs each interpolation
//  (two multiplies, sum and the 17-step divider) and then finishes.
//  Reset is synchronous; memories are not cleared.
//  Input stalls while a query runs, including while it waits for the output reg.
// ----------------------------------------------------------------------------
`include "grid_bilinear_table_lookup_defines.svh"

module grid_bilinear_table_lookup #(
  parameter int unsigned MAX_SHELLS = 64,
  parameter int unsigned MAX_ANGLES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // kind
  // row_index, column_index, grid_altitude, grid_cosine, entry_value,
  // query_altitude, query_cosine
  input  logic [159:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [0:0]   out_tuser,  // below_angle_grid
  output logic [23:0]  out_tdata,  // transmission_out
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [6:0]   cfg_wdata
);

  localparam int unsigned AW = $clog2(MAX_SHELLS);
  localparam int unsigned CW = $clog2(MAX_ANGLES);
  localparam int unsigned TD = MAX_SHELLS * MAX_ANGLES;
  localparam int unsigned TW = $clog2(TD);
  localparam int unsigned IW = (AW > CW) ? AW : CW;
  localparam int unsigned VW = gbl_pkg::VAL_W;
  localparam int unsigned PW = gbl_pkg::PT_W;
  localparam int unsigned NW = gbl_pkg::NUM_W;

  function automatic logic [TW-1:0] taddr(input logic [31:0] r, input logic [31:0] c);
    logic [31:0] a;
    a = r * 32'(MAX_ANGLES) + c;
    return a[TW-1:0];
  endfunction

  // input fields
  logic [5:0]    f_row, f_col;
  logic [PW-1:0] f_galt, f_gcos, f_qalt, f_qcos;
  logic [VW-1:0] f_entry, ent_sat;
  assign f_row   = in_tdata[5:0];
  assign f_col   = in_tdata[11:6];
  assign f_galt  = in_tdata[43:12];
  assign f_gcos  = in_tdata[75:44];
  assign f_entry = in_tdata[92:76];
  assign f_qalt  = in_tdata[124:93];
  assign f_qcos  = in_tdata[156:125];
  assign ent_sat = (f_entry > gbl_pkg::FULL_SCALE) ? gbl_pkg::FULL_SCALE : f_entry;

  gbl_pkg::state_t state_r, state_nxt;

  logic [6:0]    shells_r, angles_r;
  logic [PW-1:0] qalt_r, qcos_r;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [PW-1:0] prev_r, prev_nxt;
  logic [AW-1:0] alo_r, alo_nxt, ahi_r, ahi_nxt;
  logic [CW-1:0] col0_r, col0_nxt, col1_r, col1_nxt;
  logic          two_a_r, two_a_nxt, two_c_r, two_c_nxt, csel_r, csel_nxt;
  logic          phase_r, phase_nxt;
  logic [PW-1:0] aw_lo_r, aw_lo_nxt, aw_hi_r, aw_hi_nxt, aden_r, aden_nxt;
  logic [PW-1:0] cw_lo_r, cw_lo_nxt, cw_hi_r, cw_hi_nxt, cden_r, cden_nxt;
  logic [VW-1:0] a_r, a_nxt, opa_r, opa_nxt, opb_r, opb_nxt, v0_r, v0_nxt;
  logic [VW-1:0] res_r, res_nxt;
  logic          below_r, below_nxt;
  logic [48:0]   p0_r, p0_nxt, p1_r, p1_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic [VW-1:0] otx_r, otx_nxt;
  logic          obelow_r, obelow_nxt;

  // memories
  logic          in_acc;
  logic [PW-1:0] alt_rd, cos_rd;
  logic [VW-1:0] tab_rd;
  logic [AW-1:0] alt_ra;
  logic [CW-1:0] cos_ra;
  logic [TW-1:0] tab_ra;
  logic          we_alt, we_cos, we_tab;

  assign in_tready = (state_r == gbl_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign we_alt = in_acc && (in_tuser == gbl_pkg::KIND_ALT) && (32'(f_row) < MAX_SHELLS);
  assign we_cos = in_acc && (in_tuser == gbl_pkg::KIND_COS) && (32'(f_col) < MAX_ANGLES);
  assign we_tab = in_acc && (in_tuser == gbl_pkg::KIND_CELL) &&
                  (32'(f_row) < MAX_SHELLS) && (32'(f_col) < MAX_ANGLES);

  gbl_ram #(.WIDTH(PW), .DEPTH(MAX_SHELLS)) u_alt_ram (
    .clk(clk), .we(we_alt), .waddr(AW'(f_row)), .wdata(f_galt),
    .raddr(alt_ra), .rdata(alt_rd));
  gbl_ram #(.WIDTH(PW), .DEPTH(MAX_ANGLES)) u_cos_ram (
    .clk(clk), .we(we_cos), .waddr(CW'(f_col)), .wdata(f_gcos),
    .raddr(cos_ra), .rdata(cos_rd));
  gbl_ram #(.WIDTH(VW), .DEPTH(TD)) u_tab_ram (
    .clk(clk), .we(we_tab), .waddr(taddr(32'(f_row), 32'(f_col))), .wdata(ent_sat),
    .raddr(tab_ra), .rdata(tab_rd));

  gbl_pkg::div_req_t div_req;
  gbl_pkg::div_rsp_t div_rsp;
  gbl_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // clamped grid sizes, as last index
  logic [31:0] ns, na;
  logic [IW-1:0] nlast_a, nlast_c;
  always_comb begin
    ns = (shells_r == '0) ? 32'd1 : ((32'(shells_r) > MAX_SHELLS) ? MAX_SHELLS : 32'(shells_r));
    na = (angles_r < 7'd2) ? 32'd2 : ((32'(angles_r) > MAX_ANGLES) ? MAX_ANGLES : 32'(angles_r));
    nlast_a = IW'(ns - 32'd1);
    nlast_c = IW'(na - 32'd1);
  end

  logic [IW-1:0] idx_inc;
  assign idx_inc = idx_r + 1'b1;
  assign alt_ra  = (state_r == gbl_pkg::ST_ASCAN) ? AW'(idx_inc) : '0;
  assign cos_ra  = (state_r == gbl_pkg::ST_CSCAN) ? CW'(idx_inc) : '0;
  always_comb begin
    tab_ra = taddr(32'(ahi_r), 32'(csel_r ? col1_r : col0_r));
    if (state_r == gbl_pkg::ST_RDLO) begin
      tab_ra = taddr(32'(alo_r), 32'(csel_r ? col1_r : col0_r));
    end
  end

  // scan compare
  logic          scan_ge;
  logic [PW:0]   d_hi_v, d_v_lo, d_hi_lo;
  logic [PW-1:0] s_pt, s_val;
  always_comb begin
    s_pt    = (state_r == gbl_pkg::ST_ASCAN) ? alt_rd : cos_rd;
    s_val   = (state_r == gbl_pkg::ST_ASCAN) ? qalt_r : qcos_r;
    scan_ge = ($signed(s_pt) >= $signed(s_val));
    d_hi_v  = {s_pt[PW-1], s_pt} - {s_val[PW-1], s_val};
    d_v_lo  = {s_val[PW-1], s_val} - {prev_r[PW-1], prev_r};
    d_hi_lo = {s_pt[PW-1], s_pt} - {prev_r[PW-1], prev_r};
  end

  logic          col_fire;
  logic [VW-1:0] col_val;
  logic [PW-1:0] wlo, whi, den;
  assign wlo = phase_r ? cw_lo_r : aw_lo_r;
  assign whi = phase_r ? cw_hi_r : aw_hi_r;
  assign den = phase_r ? cden_r : aden_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;   prev_nxt = prev_r;
    alo_nxt = alo_r;   ahi_nxt = ahi_r;   col0_nxt = col0_r;  col1_nxt = col1_r;
    two_a_nxt = two_a_r; two_c_nxt = two_c_r; csel_nxt = csel_r; phase_nxt = phase_r;
    aw_lo_nxt = aw_lo_r; aw_hi_nxt = aw_hi_r; aden_nxt = aden_r;
    cw_lo_nxt = cw_lo_r; cw_hi_nxt = cw_hi_r; cden_nxt = cden_r;
    a_nxt = a_r; opa_nxt = opa_r; opb_nxt = opb_r; v0_nxt = v0_r;
    res_nxt = res_r; below_nxt = below_r;
    p0_nxt = p0_r; p1_nxt = p1_r;
    ovalid_nxt = ovalid_r && !out_tready;
    otx_nxt = otx_r; obelow_nxt = obelow_r;
    div_req.start = 1'b0;
    div_req.num   = NW'(p0_r) + NW'(p1_r) + NW'(den >> 1);
    div_req.den   = den;
    col_fire = 1'b0;
    col_val  = tab_rd;

    unique case (state_r)
      gbl_pkg::ST_IDLE: begin
        if (in_acc && (in_tuser == gbl_pkg::KIND_QRY)) begin
          idx_nxt   = '0;
          state_nxt = gbl_pkg::ST_ASCAN;
        end
      end
      gbl_pkg::ST_ASCAN: begin
        if (scan_ge || (idx_r == nlast_a)) begin
          two_a_nxt = 1'b0;
          ahi_nxt   = AW'(idx_r);
          alo_nxt   = '0;
          if (scan_ge && (idx_r != '0) && ($signed(d_hi_v) > $signed(gbl_pkg::ON_POINT_TOL))) begin
            two_a_nxt = 1'b1;
            alo_nxt   = AW'(idx_r - 1'b1);
            aw_lo_nxt = d_hi_v[PW-1:0];
            aw_hi_nxt = d_v_lo[PW-1:0];
            aden_nxt  = d_hi_lo[PW-1:0];
          end
          idx_nxt   = '0;
          state_nxt = gbl_pkg::ST_CSCAN;
        end else begin
          prev_nxt = alt_rd;
          idx_nxt  = idx_inc;
        end
      end
      gbl_pkg::ST_CSCAN: begin
        if (scan_ge && (idx_r == '0)) begin
          res_nxt   = '0;
          below_nxt = 1'b1;
          state_nxt = gbl_pkg::ST_FIN;
        end else if (scan_ge) begin
          two_c_nxt = 1'b1;
          col0_nxt  = CW'(idx_r - 1'b1);
          col1_nxt  = CW'(idx_r);
          cw_lo_nxt = d_hi_v[PW-1:0];
          cw_hi_nxt = d_v_lo[PW-1:0];
          cden_nxt  = d_hi_lo[PW-1:0];
          csel_nxt  = 1'b0;
          below_nxt = 1'b0;
          state_nxt = gbl_pkg::ST_RDLO;
        end else if (idx_r == nlast_c) begin
          two_c_nxt = 1'b0;
          col0_nxt  = CW'(idx_r);
          col1_nxt  = CW'(idx_r);
          csel_nxt  = 1'b0;
          below_nxt = 1'b0;
          state_nxt = gbl_pkg::ST_RDLO;
        end else begin
          prev_nxt = cos_rd;
          idx_nxt  = idx_inc;
        end
      end
      gbl_pkg::ST_RDLO: begin
        state_nxt = gbl_pkg::ST_RDHI;
      end
      gbl_pkg::ST_RDHI: begin
        a_nxt     = tab_rd;
        state_nxt = gbl_pkg::ST_RDWT;
      end
      gbl_pkg::ST_RDWT: begin
        if (two_a_r) begin
          opa_nxt   = a_r;
          opb_nxt   = tab_rd;
          phase_nxt = 1'b0;
          state_nxt = gbl_pkg::ST_MULA;
        end else begin
          col_fire = 1'b1;
          col_val  = tab_rd;
        end
      end
      gbl_pkg::ST_MULA: begin
        p0_nxt    = 49'(opa_r * wlo);
        state_nxt = gbl_pkg::ST_MULB;
      end
      gbl_pkg::ST_MULB: begin
        p1_nxt    = 49'(opb_r * whi);
        state_nxt = gbl_pkg::ST_SUM;
      end
      gbl_pkg::ST_SUM: begin
        div_req.start = 1'b1;
        state_nxt     = gbl_pkg::ST_DIV;
      end
      gbl_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          if (phase_r) begin
            res_nxt   = div_rsp.quot;
            state_nxt = gbl_pkg::ST_FIN;
          end else begin
            col_fire = 1'b1;
            col_val  = div_rsp.quot;
          end
        end
      end
      gbl_pkg::ST_FIN: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          otx_nxt    = (res_r > gbl_pkg::FULL_SCALE) ? gbl_pkg::FULL_SCALE : res_r;
          obelow_nxt = below_r;
          state_nxt  = gbl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gbl_pkg::ST_IDLE;
      end
    endcase

    // one column value along altitude is ready
    if (col_fire) begin
      if (!csel_r) begin
        v0_nxt = col_val;
        if (two_c_r) begin
          csel_nxt  = 1'b1;
          state_nxt = gbl_pkg::ST_RDLO;
        end else begin
          res_nxt   = col_val;
          state_nxt = gbl_pkg::ST_FIN;
        end
      end else begin
        opa_nxt   = v0_r;
        opb_nxt   = col_val;
        phase_nxt = 1'b1;
        state_nxt = gbl_pkg::ST_MULA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= gbl_pkg::ST_IDLE;
      shells_r <= 7'd64;
      angles_r <= 7'd64;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we && (cfg_index == gbl_pkg::CFG_SHELLS)) begin
        shells_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == gbl_pkg::CFG_ANGLES)) begin
        angles_r <= cfg_wdata;
      end
    end
    if (in_acc) begin
      qalt_r <= f_qalt;
      qcos_r <= f_qcos;
    end
    idx_r <= idx_nxt;     prev_r <= prev_nxt;
    alo_r <= alo_nxt;     ahi_r <= ahi_nxt;
    col0_r <= col0_nxt;   col1_r <= col1_nxt;
    two_a_r <= two_a_nxt; two_c_r <= two_c_nxt;
    csel_r <= csel_nxt;   phase_r <= phase_nxt;
    aw_lo_r <= aw_lo_nxt; aw_hi_r <= aw_hi_nxt; aden_r <= aden_nxt;
    cw_lo_r <= cw_lo_nxt; cw_hi_r <= cw_hi_nxt; cden_r <= cden_nxt;
    a_r <= a_nxt;         opa_r <= opa_nxt;     opb_r <= opb_nxt;
    v0_r <= v0_nxt;       res_r <= res_nxt;     below_r <= below_nxt;
    p0_r <= p0_nxt;       p1_r <= p1_nxt;
    otx_r <= otx_nxt;     obelow_r <= obelow_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = obelow_r;
  assign out_tdata  = {7'd0, otx_r};

  `GBL_ASSERT(a_below_zero, clk, rst_n, (out_tvalid && out_tuser[0]) |-> (otx_r == '0))
  `GBL_ASSERT(a_tx_range, clk, rst_n, out_tvalid |-> (otx_r <= gbl_pkg::FULL_SCALE))
  `GBL_ASSERT_NEVER(a_div_idle, clk, rst_n, in_tready && div_rsp.busy)

endmodule
